>>> rtl/olex_pkg.sv
// Package for the operator symbol lexer, imported by the datapath and the checker:
// token codes, result type and the longest-match classifier used by the datapath.
// No dependencies.
package olex_pkg;

  // Newline counter width; line_total shows its low 32 bits.
  localparam int LINE_COUNT_BITS = 32;
  localparam int LINE_TOTAL_BITS = 32;
  localparam int CHAR_BITS       = 8;
  localparam int CODE_BITS       = 8;
  localparam int LEN_BITS        = 2;

  // Packed widths of the stream words.
  localparam int IN_DATA_BITS   = 3 * CHAR_BITS;
  localparam int OUT_FIELD_BITS = 1 + CODE_BITS + LEN_BITS + LINE_TOTAL_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic [CODE_BITS-1:0] tok_code_t;

  localparam tok_code_t TOK_NONE        = 8'h00;
  localparam tok_code_t TOK_HASH        = 8'h01;
  localparam tok_code_t TOK_DOLLAR      = 8'h02;
  localparam tok_code_t TOK_DOLLAR2     = 8'h03;
  localparam tok_code_t TOK_BACKSLASH   = 8'h04;
  localparam tok_code_t TOK_NEWLINE     = 8'h05;
  localparam tok_code_t TOK_NOT         = 8'h80;
  localparam tok_code_t TOK_NE          = 8'h81;
  localparam tok_code_t TOK_MOD         = 8'h82;
  localparam tok_code_t TOK_AND         = 8'h83;
  localparam tok_code_t TOK_LAND        = 8'h84;
  localparam tok_code_t TOK_LPAREN      = 8'h85;
  localparam tok_code_t TOK_RPAREN      = 8'h86;
  localparam tok_code_t TOK_MUL         = 8'h87;
  localparam tok_code_t TOK_ADD         = 8'h88;
  localparam tok_code_t TOK_INC         = 8'h89;
  localparam tok_code_t TOK_COMMA       = 8'h8b;
  localparam tok_code_t TOK_SUB         = 8'h8c;
  localparam tok_code_t TOK_DEC         = 8'h8d;
  localparam tok_code_t TOK_ARROW       = 8'h8f;
  localparam tok_code_t TOK_DOT         = 8'h90;
  localparam tok_code_t TOK_ELLIPSIS    = 8'h91;
  localparam tok_code_t TOK_DIV         = 8'h92;
  localparam tok_code_t TOK_COLON       = 8'h93;
  localparam tok_code_t TOK_SEMI        = 8'h94;
  localparam tok_code_t TOK_LT          = 8'h95;
  localparam tok_code_t TOK_SHL         = 8'h96;
  localparam tok_code_t TOK_LE          = 8'h97;
  localparam tok_code_t TOK_ASSIGN      = 8'h98;
  localparam tok_code_t TOK_MOD_EQ      = 8'h99;
  localparam tok_code_t TOK_AND_EQ      = 8'h9a;
  localparam tok_code_t TOK_MUL_EQ      = 8'h9b;
  localparam tok_code_t TOK_ADD_EQ      = 8'h9c;
  localparam tok_code_t TOK_SUB_EQ      = 8'h9d;
  localparam tok_code_t TOK_DIV_EQ      = 8'h9e;
  localparam tok_code_t TOK_SHL_EQ      = 8'h9f;
  localparam tok_code_t TOK_EQ          = 8'ha0;
  localparam tok_code_t TOK_SHR_EQ      = 8'ha1;
  localparam tok_code_t TOK_XOR_EQ      = 8'ha2;
  localparam tok_code_t TOK_OR_EQ       = 8'ha3;
  localparam tok_code_t TOK_GT          = 8'ha4;
  localparam tok_code_t TOK_GE          = 8'ha5;
  localparam tok_code_t TOK_SHR         = 8'ha6;
  localparam tok_code_t TOK_QUESTION    = 8'ha7;
  localparam tok_code_t TOK_LBRACKET    = 8'ha8;
  localparam tok_code_t TOK_RBRACKET    = 8'ha9;
  localparam tok_code_t TOK_XOR         = 8'haa;
  localparam tok_code_t TOK_LBRACE      = 8'hab;
  localparam tok_code_t TOK_OR          = 8'hac;
  localparam tok_code_t TOK_LOR         = 8'had;
  localparam tok_code_t TOK_RBRACE      = 8'hae;
  localparam tok_code_t TOK_TILDE       = 8'haf;

  // Source characters used by the matcher.
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_QUEST  = 8'h3f;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRK   = 8'h5d;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_TILDE  = 8'h7e;

  typedef struct packed {
    tok_code_t           code;
    logic [LEN_BITS-1:0] len;
  } tok_res_t;

  function automatic tok_res_t mk(input tok_code_t code, input logic [LEN_BITS-1:0] len);
    tok_res_t r;
    r.code = code;
    r.len  = len;
    return r;
  endfunction

  // Longest match of up to three characters starting at c0.
  function automatic tok_res_t classify(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2);
    tok_res_t r;
    r = mk(TOK_NONE, 2'd0);
    unique case (c0)
      CH_LF:     r = mk(TOK_NEWLINE, 2'd1);
      CH_CR:     r = (c1 == CH_LF) ? mk(TOK_NEWLINE, 2'd2) : mk(TOK_NEWLINE, 2'd1);
      CH_BANG:   r = (c1 == CH_EQ) ? mk(TOK_NE, 2'd2) : mk(TOK_NOT, 2'd1);
      CH_HASH:   r = mk(TOK_HASH, 2'd1);
      CH_DOLLAR: r = (c1 == CH_DOLLAR) ? mk(TOK_DOLLAR2, 2'd2) : mk(TOK_DOLLAR, 2'd1);
      CH_PCT:    r = (c1 == CH_EQ) ? mk(TOK_MOD_EQ, 2'd2) : mk(TOK_MOD, 2'd1);
      CH_AMP: begin
        if (c1 == CH_AMP)     r = mk(TOK_LAND, 2'd2);
        else if (c1 == CH_EQ) r = mk(TOK_AND_EQ, 2'd2);
        else                  r = mk(TOK_AND, 2'd1);
      end
      CH_LPAR:   r = mk(TOK_LPAREN, 2'd1);
      CH_RPAR:   r = mk(TOK_RPAREN, 2'd1);
      CH_STAR:   r = (c1 == CH_EQ) ? mk(TOK_MUL_EQ, 2'd2) : mk(TOK_MUL, 2'd1);
      CH_PLUS: begin
        if (c1 == CH_PLUS)    r = mk(TOK_INC, 2'd2);
        else if (c1 == CH_EQ) r = mk(TOK_ADD_EQ, 2'd2);
        else                  r = mk(TOK_ADD, 2'd1);
      end
      CH_COMMA:  r = mk(TOK_COMMA, 2'd1);
      CH_MINUS: begin
        if (c1 == CH_MINUS)   r = mk(TOK_DEC, 2'd2);
        else if (c1 == CH_EQ) r = mk(TOK_SUB_EQ, 2'd2);
        else if (c1 == CH_GT) r = mk(TOK_ARROW, 2'd2);
        else                  r = mk(TOK_SUB, 2'd1);
      end
      CH_DOT: begin
        if (c1 == CH_DOT && c2 == CH_DOT) r = mk(TOK_ELLIPSIS, 2'd3);
        else                              r = mk(TOK_DOT, 2'd1);
      end
      CH_SLASH:  r = (c1 == CH_EQ) ? mk(TOK_DIV_EQ, 2'd2) : mk(TOK_DIV, 2'd1);
      CH_COLON:  r = mk(TOK_COLON, 2'd1);
      CH_SEMI:   r = mk(TOK_SEMI, 2'd1);
      CH_LT: begin
        if (c1 == CH_LT && c2 == CH_EQ) r = mk(TOK_SHL_EQ, 2'd3);
        else if (c1 == CH_LT)           r = mk(TOK_SHL, 2'd2);
        else if (c1 == CH_EQ)           r = mk(TOK_LE, 2'd2);
        else                            r = mk(TOK_LT, 2'd1);
      end
      CH_EQ:     r = (c1 == CH_EQ) ? mk(TOK_EQ, 2'd2) : mk(TOK_ASSIGN, 2'd1);
      CH_GT: begin
        if (c1 == CH_GT && c2 == CH_EQ) r = mk(TOK_SHR_EQ, 2'd3);
        else if (c1 == CH_GT)           r = mk(TOK_SHR, 2'd2);
        else if (c1 == CH_EQ)           r = mk(TOK_GE, 2'd2);
        else                            r = mk(TOK_GT, 2'd1);
      end
      CH_QUEST:  r = mk(TOK_QUESTION, 2'd1);
      CH_LBRK:   r = mk(TOK_LBRACKET, 2'd1);
      CH_BSLASH: r = mk(TOK_BACKSLASH, 2'd1);
      CH_RBRK:   r = mk(TOK_RBRACKET, 2'd1);
      CH_CARET:  r = (c1 == CH_EQ) ? mk(TOK_XOR_EQ, 2'd2) : mk(TOK_XOR, 2'd1);
      CH_LBRACE: r = mk(TOK_LBRACE, 2'd1);
      CH_BAR: begin
        if (c1 == CH_EQ)       r = mk(TOK_OR_EQ, 2'd2);
        else if (c1 == CH_BAR) r = mk(TOK_LOR, 2'd2);
        else                   r = mk(TOK_OR, 2'd1);
      end
      CH_RBRACE: r = mk(TOK_RBRACE, 2'd1);
      CH_TILDE:  r = mk(TOK_TILDE, 2'd1);
      default:   r = mk(TOK_NONE, 2'd0);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/operator_symbol_lexer.sv
// Operator symbol lexer: one word in per cycle unless stalled, longest-match token out.
// An input register and a result register lie between input accept and result valid.
// Throughput: one word per cycle unless stalled; classifier: one level of byte compares.
// The newline counter updates as a word moves from the input to the result register.
// Reset (rst_n low, synchronous) empties both registers and clears the newline counter.
// Depends on olex_pkg.
module operator_symbol_lexer
  import olex_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // cur_char, next_char, third_char
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata   // matched, token_code, token_length,
                                               // line_total, zero pad
);

  logic                       s1_vld_r;
  logic [IN_DATA_BITS-1:0]    s1_data_r;
  logic                       s2_vld_r;
  logic                       s2_match_r;
  tok_res_t                   s2_res_r;
  logic [LINE_COUNT_BITS-1:0] line_cnt_r;
  logic [LINE_COUNT_BITS-1:0] line_cnt_nxt;
  logic [63:0]                line_ext;
  logic                       s1_adv;
  tok_res_t                   res;
  logic                       is_nl;

  assign s1_adv    = s1_vld_r && (!s2_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;

  always_comb begin
    res          = classify(s1_data_r[7:0], s1_data_r[15:8], s1_data_r[23:16]);
    is_nl        = (res.len != '0) && (res.code == TOK_NEWLINE);
    line_cnt_nxt = line_cnt_r + LINE_COUNT_BITS'(is_nl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      line_cnt_r <= '0;
    end else begin
      if (in_tready) s1_vld_r <= in_tvalid;
      if (s1_adv) begin
        s2_vld_r   <= 1'b1;
        line_cnt_r <= line_cnt_nxt;
      end else if (out_tready) begin
        s2_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_data_r <= in_tdata;
    if (s1_adv) begin
      s2_res_r   <= res;
      s2_match_r <= (res.len != '0);
    end
  end

  assign line_ext   = 64'(line_cnt_r);
  assign out_tvalid = s2_vld_r;
  assign out_tdata  = OUT_DATA_BITS'({line_ext[LINE_TOTAL_BITS-1:0], s2_res_r.len,
                                      s2_res_r.code, s2_match_r});

endmodule

>>> rtl/olex_checker.sv
// Port-level checker for operator_symbol_lexer, attached by bind.
// Depends on olex_pkg.
module olex_checker
  import olex_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic [IN_DATA_BITS-1:0]  in_tdata,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata
);

  localparam logic [LINE_TOTAL_BITS-1:0] TotalMask =
    (LINE_COUNT_BITS >= LINE_TOTAL_BITS) ? '1 :
    LINE_TOTAL_BITS'((64'd1 << LINE_COUNT_BITS) - 64'd1);

  logic                       o_match;
  tok_code_t                  o_code;
  logic [LEN_BITS-1:0]        o_len;
  logic [LINE_TOTAL_BITS-1:0] o_total;
  logic [LINE_TOTAL_BITS-1:0] last_total_r;
  logic [LINE_TOTAL_BITS-1:0] exp_total;
  logic                       o_nl;
  logic [2:0]                 in_flight_r;

  assign o_match   = out_tdata[0];
  assign o_code    = out_tdata[8:1];
  assign o_len     = out_tdata[10:9];
  assign o_total   = out_tdata[42:11];
  assign o_nl      = o_match && (o_code == TOK_NEWLINE);
  assign exp_total = (last_total_r + LINE_TOTAL_BITS'(o_nl)) & TotalMask;

  // Running view of the count and of words accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_total_r <= '0;
      in_flight_r  <= '0;
    end else begin
      if (out_tvalid && out_tready) last_total_r <= o_total;
      in_flight_r <= in_flight_r + 3'(in_tvalid && in_tready) - 3'(out_tvalid && out_tready);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_match ? (o_len != '0) : (o_len == '0 && o_code == TOK_NONE)))
    else $error("match flag disagrees with token length or code");

  a_line_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> o_total == exp_total)
    else $error("line total does not follow newline tokens");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> in_flight_r != 3'd0)
    else $error("result word without an accepted input word");

endmodule

bind operator_symbol_lexer olex_checker u_olex_checker (.*);
